// ----- design/tcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// tcsa_pkg
// shared types, codes and widths of the texture chunk stream admission block
// ----------------------------------------------------------------------------
`default_nettype none

package tcsa_pkg;

  localparam int unsigned MAX_MIP_LEVELS_DEF = 16;

  localparam int unsigned EDGE_W   = 16;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned MCAP_W   = 16;
  localparam int unsigned BLOCKS_W = 15;   // ceil(65535/4) fits in 15 bits
  localparam int unsigned LEVEL_W  = 33;   // blocks^2 * 8
  localparam int unsigned CHAIN_W  = 34;   // geometric sum stays below 2^33
  localparam int unsigned BBYTES_W = 40;
  localparam int unsigned BUF_W    = 33;
  localparam int unsigned MCNT_W   = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned OUT_TDATA_W = 184;

  // reset values of the registers
  localparam logic [EDGE_W-1:0] MAX_EDGE_RST  = 16'd4096;
  localparam logic [LEN_W-1:0]  MAX_PAY_RST   = 32'd16777216;
  localparam logic [LEN_W-1:0]  BUDGET_RST    = 32'd4194304;
  localparam logic [LEN_W-1:0]  POOL_SIZE_RST = 32'd0;
  localparam logic [LEN_W-1:0]  BYTE_CAP_RST  = 32'd16777216;
  localparam logic [MCAP_W-1:0] MSG_CAP_RST   = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_ACTIVE = 3'd0,
    CFG_MAX_EDGE    = 3'd1,
    CFG_MAX_PAYLOAD = 3'd2,
    CFG_BUDGET      = 3'd3,
    CFG_POOL_SIZE   = 3'd4,
    CFG_BYTE_CAP    = 3'd5,
    CFG_MSG_CAP     = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_ERROR     = 2'd1,
    ST_DEFERRED  = 2'd2,
    ST_FOUND     = 2'd3
  } cell_status_t;

  typedef enum logic [1:0] {
    BS_RUNNING   = 2'd0,
    BS_COMPLETE  = 2'd1,
    BS_EXHAUSTED = 2'd2,
    BS_INACTIVE  = 2'd3
  } batch_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_RUN    = 2'd1,
    FSM_DECIDE = 2'd2
  } fsm_state_t;

  // result of the mip chain unit
  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] base;
    logic [CHAIN_W-1:0] chain;
  } mip_res_t;

  // checks done while the mip chain is summed
  typedef struct packed {
    logic shape_pre_ok;
    logic pool_ok;
    logic budget_ok;
    logic cap_ok;
    logic msg_full;
  } chk_flags_t;

endpackage

`default_nettype wire

// ----- design/texture_chunk_stream_admission_top.sv -----
// ----------------------------------------------------------------------------
// texture_chunk_stream_admission_top
// per-cell admission of pooled dxt1 texture chunks into an output batch
// ----------------------------------------------------------------------------
// One cell is handled at a time. The mip chain unit sums the mip levels of the
// cell's edge (1 to MAX_MIP_LEVELS, halving the edge down to 1), one level per
// cycle on a single multiplier; its registered done flag hands the finished
// sum over, and the decide state turns the checks into a status.
// in_tready is high only while no cell is in work;
// a finished result sits in the output register, so the next cell is taken
// while the result still waits for out_tready. Configuration is written
// through cfg_we/cfg_index/cfg_wdata and must only change while the block is
// idle. batch_first (in_tuser) clears the batch counters on accept.
`default_nettype none

module texture_chunk_stream_admission_top #(
  parameter int unsigned MAX_MIP_LEVELS = tcsa_pkg::MAX_MIP_LEVELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // cell_x, cell_y, record_present, edge_texels, payload_length,
  // pool_offset, zero fill
  input  wire logic [tcsa_pkg::IN_TDATA_W-1:0]    in_tdata,
  // batch_first
  input  wire logic                               in_tuser,
  // batch_last
  input  wire logic                               in_tlast,
  // result channel
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // out_cell_x, out_cell_y, cell_status, out_edge, out_length, copy_source,
  // copy_dest, batch_state, zero fill
  output      logic [tcsa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // message_emitted
  output      logic                               out_tuser,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [tcsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcsa_pkg::CFG_W-1:0]         cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic                          pool_active_r;
  logic [tcsa_pkg::EDGE_W-1:0]   max_edge_r;
  logic [tcsa_pkg::LEN_W-1:0]    max_payload_r;
  logic [tcsa_pkg::LEN_W-1:0]    batch_budget_r;
  logic [tcsa_pkg::LEN_W-1:0]    pool_size_r;
  logic [tcsa_pkg::LEN_W-1:0]    byte_cap_r;
  logic [tcsa_pkg::MCAP_W-1:0]   msg_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_active_r  <= 1'b0;
      max_edge_r     <= tcsa_pkg::MAX_EDGE_RST;
      max_payload_r  <= tcsa_pkg::MAX_PAY_RST;
      batch_budget_r <= tcsa_pkg::BUDGET_RST;
      pool_size_r    <= tcsa_pkg::POOL_SIZE_RST;
      byte_cap_r     <= tcsa_pkg::BYTE_CAP_RST;
      msg_cap_r      <= tcsa_pkg::MSG_CAP_RST;
    end else if (cfg_we) begin
      case (tcsa_pkg::cfg_idx_t'(cfg_index))
        tcsa_pkg::CFG_POOL_ACTIVE: pool_active_r  <= cfg_wdata[0];
        tcsa_pkg::CFG_MAX_EDGE:    max_edge_r     <= cfg_wdata[tcsa_pkg::EDGE_W-1:0];
        tcsa_pkg::CFG_MAX_PAYLOAD: max_payload_r  <= cfg_wdata;
        tcsa_pkg::CFG_BUDGET:      batch_budget_r <= cfg_wdata;
        tcsa_pkg::CFG_POOL_SIZE:   pool_size_r    <= cfg_wdata;
        tcsa_pkg::CFG_BYTE_CAP:    byte_cap_r     <= cfg_wdata;
        tcsa_pkg::CFG_MSG_CAP:     msg_cap_r      <= cfg_wdata[tcsa_pkg::MCAP_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------- input fields
  logic                                 in_accept;
  logic signed [tcsa_pkg::COORD_W-1:0]  in_cell_x, in_cell_y;
  logic                                 in_present;
  logic [tcsa_pkg::EDGE_W-1:0]          in_edge;
  logic [tcsa_pkg::LEN_W-1:0]           in_len, in_offs;

  assign in_accept  = in_tvalid && in_tready;
  assign in_cell_x  = in_tdata[31:0];
  assign in_cell_y  = in_tdata[63:32];
  assign in_present = in_tdata[64];
  assign in_edge    = in_tdata[80:65];
  assign in_len     = in_tdata[112:81];
  assign in_offs    = in_tdata[144:113];

  // held cell, captured on accept
  logic signed [tcsa_pkg::COORD_W-1:0]  cx_r, cy_r;
  logic                                 last_r, present_r;
  logic [tcsa_pkg::EDGE_W-1:0]          edge_r;
  logic [tcsa_pkg::LEN_W-1:0]           len_r, offs_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cx_r      <= in_cell_x;
      cy_r      <= in_cell_y;
      last_r    <= in_tlast;
      present_r <= in_present;
      edge_r    <= in_edge;
      len_r     <= in_len;
      offs_r    <= in_offs;
    end
  end

  // ----------------------------------------------------------- batch state
  logic [tcsa_pkg::BBYTES_W-1:0] batch_bytes_r, batch_bytes_nxt;
  logic [tcsa_pkg::BUF_W-1:0]    buffered_r, buffered_nxt;
  logic [tcsa_pkg::MCNT_W-1:0]   msg_count_r, msg_count_nxt;
  logic                          exhausted_r, exhausted_nxt;

  // ------------------------------------------------------------ sequencer
  tcsa_pkg::fsm_state_t state_r, state_nxt;
  tcsa_pkg::mip_res_t   mip_res;
  tcsa_pkg::chk_flags_t flags_r, flags_nxt;

  logic mip_start;
  logic want_result;   // this cell yields a result
  logic out_free;      // output register can take a result
  logic commit;        // decide cycle completes

  tcsa_mip_unit #(
    .MAX_MIP_LEVELS (MAX_MIP_LEVELS)
  ) u_mip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mip_start),
    .edge_in (in_edge),
    .res     (mip_res)
  );

  // checks that do not need the chain, evaluated while the chain is summed
  always_comb begin
    flags_nxt.shape_pre_ok = (edge_r != '0) && (edge_r <= max_edge_r) &&
                             (len_r != '0) && (len_r <= max_payload_r);
    flags_nxt.pool_ok   = ({1'b0, offs_r} + {1'b0, len_r}) <= {1'b0, pool_size_r};
    flags_nxt.budget_ok = (batch_bytes_r == '0) ||
                          (({1'b0, batch_bytes_r} + (tcsa_pkg::BBYTES_W+1)'(len_r)) <=
                           (tcsa_pkg::BBYTES_W+1)'(batch_budget_r));
    flags_nxt.cap_ok    = (({1'b0, buffered_r} + (tcsa_pkg::BUF_W+1)'(len_r)) <=
                           (tcsa_pkg::BUF_W+1)'(byte_cap_r));
    flags_nxt.msg_full  = msg_count_r >= tcsa_pkg::MCNT_W'(msg_cap_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == tcsa_pkg::FSM_RUN) begin
      flags_r <= flags_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcsa_pkg::FSM_IDLE:   if (in_accept) state_nxt = tcsa_pkg::FSM_RUN;
      tcsa_pkg::FSM_RUN:    if (mip_res.done) state_nxt = tcsa_pkg::FSM_DECIDE;
      tcsa_pkg::FSM_DECIDE: if (commit) state_nxt = tcsa_pkg::FSM_IDLE;
      default:              state_nxt = tcsa_pkg::FSM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready   = 1'b0;
    mip_start   = 1'b0;
    commit      = 1'b0;
    want_result = !pool_active_r || !exhausted_r;
    out_free    = !out_tvalid || out_tready;
    unique case (state_r)
      tcsa_pkg::FSM_IDLE: begin
        in_tready = 1'b1;
        mip_start = in_tvalid;
      end
      tcsa_pkg::FSM_RUN: ;
      tcsa_pkg::FSM_DECIDE: commit = !want_result || out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcsa_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------- decision
  tcsa_pkg::cell_status_t status;
  logic                   shape_ok;

  assign shape_ok = flags_r.shape_pre_ok &&
                    ((tcsa_pkg::LEVEL_W'(len_r) == mip_res.base) ||
                     (tcsa_pkg::CHAIN_W'(len_r) == mip_res.chain));

  always_comb begin
    priority if (!present_r) begin
      status = tcsa_pkg::ST_NOT_FOUND;
    end else if (!shape_ok || !flags_r.pool_ok) begin
      status = tcsa_pkg::ST_ERROR;
    end else if (!flags_r.budget_ok || !flags_r.cap_ok) begin
      status = tcsa_pkg::ST_DEFERRED;
    end else begin
      status = tcsa_pkg::ST_FOUND;
    end
  end

  // result register
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 emit_r, emit_nxt;
  logic signed [tcsa_pkg::COORD_W-1:0]  ocx_r, ocx_nxt, ocy_r, ocy_nxt;
  tcsa_pkg::cell_status_t               ostat_r, ostat_nxt;
  logic [tcsa_pkg::EDGE_W-1:0]          oedge_r, oedge_nxt;
  logic [tcsa_pkg::LEN_W-1:0]           olen_r, olen_nxt, osrc_r, osrc_nxt;
  logic [tcsa_pkg::LEN_W-1:0]           odst_r, odst_nxt;
  tcsa_pkg::batch_state_t               obs_r, obs_nxt;
  logic                                 load_out;

  assign load_out = commit && want_result;

  always_comb begin
    batch_bytes_nxt = batch_bytes_r;
    buffered_nxt    = buffered_r;
    msg_count_nxt   = msg_count_r;
    exhausted_nxt   = exhausted_r;

    out_valid_nxt = out_valid_r && !out_tready;
    emit_nxt  = emit_r;
    ocx_nxt   = ocx_r;
    ocy_nxt   = ocy_r;
    ostat_nxt = ostat_r;
    oedge_nxt = oedge_r;
    olen_nxt  = olen_r;
    osrc_nxt  = osrc_r;
    odst_nxt  = odst_r;
    obs_nxt   = obs_r;

    // batch_first clears the counters before the cell is judged
    if (in_accept && in_tuser) begin
      batch_bytes_nxt = '0;
      buffered_nxt    = '0;
      msg_count_nxt   = '0;
      exhausted_nxt   = 1'b0;
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
      emit_nxt  = 1'b0;
      ocx_nxt   = '0;
      ocy_nxt   = '0;
      ostat_nxt = tcsa_pkg::ST_NOT_FOUND;
      oedge_nxt = '0;
      olen_nxt  = '0;
      osrc_nxt  = '0;
      odst_nxt  = '0;
      if (!pool_active_r) begin
        obs_nxt = tcsa_pkg::BS_INACTIVE;
      end else if (flags_r.msg_full) begin
        // message list overflow: drop the outcome, mute the rest of the batch
        exhausted_nxt = 1'b1;
        obs_nxt       = tcsa_pkg::BS_EXHAUSTED;
      end else begin
        msg_count_nxt = msg_count_r + tcsa_pkg::MCNT_W'(1);
        emit_nxt  = 1'b1;
        ocx_nxt   = cx_r;
        ocy_nxt   = cy_r;
        ostat_nxt = status;
        oedge_nxt = present_r ? edge_r : '0;
        obs_nxt   = last_r ? tcsa_pkg::BS_COMPLETE : tcsa_pkg::BS_RUNNING;
        if (status == tcsa_pkg::ST_FOUND) begin
          olen_nxt        = len_r;
          osrc_nxt        = offs_r;
          odst_nxt        = buffered_r[tcsa_pkg::LEN_W-1:0];
          buffered_nxt    = buffered_r + tcsa_pkg::BUF_W'(len_r);
          batch_bytes_nxt = batch_bytes_r + tcsa_pkg::BBYTES_W'(len_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_bytes_r <= '0;
      buffered_r    <= '0;
      msg_count_r   <= '0;
      exhausted_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      batch_bytes_r <= batch_bytes_nxt;
      buffered_r    <= buffered_nxt;
      msg_count_r   <= msg_count_nxt;
      exhausted_r   <= exhausted_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    emit_r  <= emit_nxt;
    ocx_r   <= ocx_nxt;
    ocy_r   <= ocy_nxt;
    ostat_r <= ostat_nxt;
    oedge_r <= oedge_nxt;
    olen_r  <= olen_nxt;
    osrc_r  <= osrc_nxt;
    odst_r  <= odst_nxt;
    obs_r   <= obs_nxt;
  end

  // ------------------------------------------------------------- outputs
  assign out_tvalid = out_valid_r;
  assign out_tuser  = emit_r;
  assign out_tdata  = {4'b0000, obs_r, odst_r, osrc_r, olen_r, oedge_r, ostat_r,
                       ocy_r, ocx_r};

endmodule

`default_nettype wire

// ----- design/tcsa_mip_unit.sv -----
// ----------------------------------------------------------------------------
// tcsa_mip_unit
// sums the dxt1 mip chain of one edge, one level per cycle, on one multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module tcsa_mip_unit #(
  parameter int unsigned MAX_MIP_LEVELS = tcsa_pkg::MAX_MIP_LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tcsa_pkg::EDGE_W-1:0] edge_in,
  output tcsa_pkg::mip_res_t               res
);

  localparam int unsigned CNT_W = (MAX_MIP_LEVELS > 1) ? $clog2(MAX_MIP_LEVELS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_MIP_LEVELS - 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [tcsa_pkg::EDGE_W-1:0]   e_r, e_nxt;
  logic [tcsa_pkg::CHAIN_W-1:0]  chain_r, chain_nxt;
  logic [tcsa_pkg::LEVEL_W-1:0]  base_r, base_nxt;

  logic [tcsa_pkg::EDGE_W:0]       e_plus3;
  logic [tcsa_pkg::BLOCKS_W-1:0]   blocks;
  logic [2*tcsa_pkg::BLOCKS_W-1:0] sq;
  logic [tcsa_pkg::LEVEL_W-1:0]    lvl;
  logic                            last_lvl;

  // ceil(e/4)^2 * 8 for the current level
  assign e_plus3  = {1'b0, e_r} + (tcsa_pkg::EDGE_W+1)'(3);
  assign blocks   = e_plus3[tcsa_pkg::BLOCKS_W+1:2];
  assign sq       = blocks * blocks;
  assign lvl      = {sq, 3'b000};
  assign last_lvl = (e_r <= tcsa_pkg::EDGE_W'(1)) || (cnt_r == CNT_LAST);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    e_nxt     = e_r;
    chain_nxt = chain_r;
    base_nxt  = base_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      e_nxt     = edge_in;
      chain_nxt = '0;
    end else if (busy_r) begin
      chain_nxt = chain_r + tcsa_pkg::CHAIN_W'(lvl);
      if (cnt_r == '0) begin
        base_nxt = lvl;
      end
      if (last_lvl) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        e_nxt   = e_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    e_r     <= e_nxt;
    chain_r <= chain_nxt;
    base_r  <= base_nxt;
  end

  assign res.done  = done_r;
  assign res.base  = base_r;
  assign res.chain = chain_r;

endmodule

`default_nettype wire

// ----- design/tcsa_checker.sv -----
// ----------------------------------------------------------------------------
// tcsa_checker
// port-level checks of the admission block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tcsa_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [tcsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tuser
);

  // one cell in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // no message means every field but batch_state is zero
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[177:0] == '0))
    else $error("result without message carries data");

  // only found cells carry a length and a copy command
  a_copy_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && (out_tdata[65:64] != tcsa_pkg::ST_FOUND))
      |-> (out_tdata[177:82] == '0))
    else $error("copy command on a cell that was not found");

  // a cell without record reports no edge
  a_nf_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && (out_tdata[65:64] == tcsa_pkg::ST_NOT_FOUND))
      |-> (out_tdata[81:66] == '0))
    else $error("not found cell reports an edge");

endmodule

bind texture_chunk_stream_admission_top tcsa_checker u_tcsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- test/texture_chunk_stream_admission_top_tb.sv -----
// ----------------------------------------------------------------------------
// texture_chunk_stream_admission_top_tb
// self-checking bench for per-cell admission of pooled dxt1 texture chunks
// ----------------------------------------------------------------------------
// Cells are driven over the input stream with random gaps, and the result
// stream is stalled at random. A tracker class mirrors the registers and
// the batch counters, predicts one outcome per accepted cell (or none once
// the message list has run out) and checks every result transaction
// field by field. A short directed run covers the inactive pool, every
// status and every rejection reason. Random phases follow, each under its
// own register setting, the extremes among them.
`timescale 1ns / 100ps

module texture_chunk_stream_admission_top_tb;

  localparam int CLK_HALF       = 5;
  localparam int SETTLE_CYCLES  = 40;    // outlasts the longest cell
  localparam int WATCHDOG_LIMIT = 3000;

  // one cell as it enters the block
  typedef struct packed {
    logic        first;
    logic        last;
    logic [31:0] x;
    logic [31:0] y;
    logic        present;
    logic [15:0] edge_tx;
    logic [31:0] len;
    logic [31:0] offs;
  } cell_t;

  // one outcome as it leaves the block
  typedef struct packed {
    logic                   emitted;
    logic [31:0]            x;
    logic [31:0]            y;
    tcsa_pkg::cell_status_t status;
    logic [15:0]            edge_tx;
    logic [31:0]            len;
    logic [31:0]            src;
    logic [31:0]            dst;
    tcsa_pkg::batch_state_t bstate;
  } outcome_t;

  typedef struct packed {
    logic        active;
    logic [15:0] max_edge;
    logic [31:0] max_payload;
    logic [31:0] budget;
    logic [31:0] pool_size;
    logic [31:0] byte_cap;
    logic [15:0] msg_cap;
  } admit_cfg_t;

  // --------------------------------------------------------------------------
  // outcome tracker: register copy, batch counters and pending outcomes
  // --------------------------------------------------------------------------
  class chunk_admission_tracker;
    admit_cfg_t      cfg;
    longint unsigned batch_bytes;
    longint unsigned buffered_bytes;
    longint unsigned message_count;
    bit              exhausted;
    outcome_t        pending_outcomes[$];
    int              mismatch_count;

    function new();
      cfg.active      = 1'b0;
      cfg.max_edge    = tcsa_pkg::MAX_EDGE_RST;
      cfg.max_payload = tcsa_pkg::MAX_PAY_RST;
      cfg.budget      = tcsa_pkg::BUDGET_RST;
      cfg.pool_size   = tcsa_pkg::POOL_SIZE_RST;
      cfg.byte_cap    = tcsa_pkg::BYTE_CAP_RST;
      cfg.msg_cap     = tcsa_pkg::MSG_CAP_RST;
      batch_bytes     = 0;
      buffered_bytes  = 0;
      message_count   = 0;
      exhausted       = 1'b0;
      mismatch_count  = 0;
    endfunction

    function void write_reg(tcsa_pkg::cfg_idx_t idx, logic [31:0] val);
      case (idx)
        tcsa_pkg::CFG_POOL_ACTIVE: cfg.active      = val[0];
        tcsa_pkg::CFG_MAX_EDGE:    cfg.max_edge    = val[15:0];
        tcsa_pkg::CFG_MAX_PAYLOAD: cfg.max_payload = val;
        tcsa_pkg::CFG_BUDGET:      cfg.budget      = val;
        tcsa_pkg::CFG_POOL_SIZE:   cfg.pool_size   = val;
        tcsa_pkg::CFG_BYTE_CAP:    cfg.byte_cap    = val;
        tcsa_pkg::CFG_MSG_CAP:     cfg.msg_cap     = val[15:0];
        default: ;
      endcase
    endfunction

    // one dxt1 level: 4x4 blocks of 8 bytes
    static function longint unsigned level_bytes(longint unsigned e);
      longint unsigned blocks;
      blocks = (e + 3) / 4;
      return blocks * blocks * 8;
    endfunction

    // full chain, edge halved down to 1, capped at the level limit
    static function longint unsigned chain_bytes(longint unsigned e);
      longint unsigned sum;
      longint unsigned lvl_edge;
      sum = 0;
      lvl_edge = e;
      for (int lvl = 0; lvl < tcsa_pkg::MAX_MIP_LEVELS_DEF; lvl++) begin
        sum += level_bytes(lvl_edge);
        if (lvl_edge <= 1) break;
        lvl_edge >>= 1;
      end
      return sum;
    endfunction

    function bit shape_ok(longint unsigned e, longint unsigned len);
      if (e == 0 || e > cfg.max_edge || len == 0 || len > cfg.max_payload)
        return 1'b0;
      return len == level_bytes(e) || len == chain_bytes(e);
    endfunction

    // append one predicted outcome at the tail
    function void enqueue_outcome(outcome_t o);
      pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    function void accept_cell(cell_t c);
      outcome_t               o;
      tcsa_pkg::cell_status_t st;
      longint unsigned        len;
      if (c.first) begin
        batch_bytes    = 0;
        buffered_bytes = 0;
        message_count  = 0;
        exhausted      = 1'b0;
      end
      o = '0;
      if (!cfg.active) begin
        o.bstate = tcsa_pkg::BS_INACTIVE;
        enqueue_outcome(o);
        return;
      end
      // rest of an exhausted batch is silent
      if (exhausted) return;
      len = c.len;
      if (!c.present) begin
        st = tcsa_pkg::ST_NOT_FOUND;
      end else begin
        o.edge_tx = c.edge_tx;
        if (!shape_ok(c.edge_tx, len) || 64'(c.offs) + len > 64'(cfg.pool_size)) begin
          st = tcsa_pkg::ST_ERROR;
        end else if (batch_bytes != 0 && batch_bytes + len > 64'(cfg.budget)) begin
          st = tcsa_pkg::ST_DEFERRED;
        end else if (buffered_bytes + len > 64'(cfg.byte_cap)) begin
          st = tcsa_pkg::ST_DEFERRED;
        end else begin
          st    = tcsa_pkg::ST_FOUND;
          o.len = c.len;
          o.src = c.offs;
          o.dst = buffered_bytes[31:0];
        end
      end
      if (message_count >= cfg.msg_cap) begin
        exhausted = 1'b1;
        o = '0;
        o.bstate = tcsa_pkg::BS_EXHAUSTED;
        enqueue_outcome(o);
        return;
      end
      message_count++;
      if (st == tcsa_pkg::ST_FOUND) begin
        buffered_bytes += len;
        batch_bytes    += len;
      end
      o.emitted = 1'b1;
      o.x       = c.x;
      o.y       = c.y;
      o.status  = st;
      o.bstate  = c.last ? tcsa_pkg::BS_COMPLETE : tcsa_pkg::BS_RUNNING;
      enqueue_outcome(o);
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        mismatch_count++;
      end
    endfunction

    function void check_outcome(logic [tcsa_pkg::OUT_TDATA_W-1:0] d, logic emitted);
      outcome_t e;
      if (pending_outcomes.size() == 0) begin
        $error("result transaction with no outcome pending: tdata %0h", d);
        mismatch_count++;
        return;
      end
      e = pending_outcomes.pop_front();
      check_field("message_emitted", 64'(e.emitted), 64'(emitted));
      check_field("out_cell_x",      64'(e.x),       64'(d[31:0]));
      check_field("out_cell_y",      64'(e.y),       64'(d[63:32]));
      check_field("cell_status",     64'(e.status),  64'(d[65:64]));
      check_field("out_edge",        64'(e.edge_tx), 64'(d[81:66]));
      check_field("out_length",      64'(e.len),     64'(d[113:82]));
      check_field("copy_source",     64'(e.src),     64'(d[145:114]));
      check_field("copy_dest",       64'(e.dst),     64'(d[177:146]));
      check_field("batch_state",     64'(e.bstate),  64'(d[179:178]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports (every input driven to a known value from time zero)
  // --------------------------------------------------------------------------
  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [tcsa_pkg::IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                              in_tuser   = 1'b0;
  logic                              in_tlast   = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [tcsa_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                              out_tuser;
  logic                              cfg_we     = 1'b0;
  logic [tcsa_pkg::CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [tcsa_pkg::CFG_W-1:0]        cfg_wdata  = '0;

  int in_idle_pct   = 15;
  int out_stall_pct = 15;
  int quiet_cycles  = 0;

  chunk_admission_tracker tracker = new();

  texture_chunk_stream_admission_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // receiver backpressure, changed on the falling edge only
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: every transaction is taken at the rising edge, plus the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_blk
    cell_t seen;
    bit    moved;
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      seen.first   = in_tuser;
      seen.last    = in_tlast;
      seen.x       = in_tdata[31:0];
      seen.y       = in_tdata[63:32];
      seen.present = in_tdata[64];
      seen.edge_tx = in_tdata[80:65];
      seen.len     = in_tdata[112:81];
      seen.offs    = in_tdata[144:113];
      // note the new cell first: its own result can never show in this cycle
      tracker.accept_cell(seen);
      moved = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_outcome(out_tdata, out_tuser);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drive tasks, all entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_cell(cell_t c);
    // random gap before the transaction
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.first;
    in_tlast  <= c.last;
    in_tdata  <= {7'b0, c.offs, c.len, c.edge_tx, c.present, c.y, c.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // every register is written, only while the block is idle
  task automatic program_regs(admit_cfg_t v);
    logic [31:0] vals [7];
    vals[tcsa_pkg::CFG_POOL_ACTIVE] = {31'b0, v.active};
    vals[tcsa_pkg::CFG_MAX_EDGE]    = {16'b0, v.max_edge};
    vals[tcsa_pkg::CFG_MAX_PAYLOAD] = v.max_payload;
    vals[tcsa_pkg::CFG_BUDGET]      = v.budget;
    vals[tcsa_pkg::CFG_POOL_SIZE]   = v.pool_size;
    vals[tcsa_pkg::CFG_BYTE_CAP]    = v.byte_cap;
    vals[tcsa_pkg::CFG_MSG_CAP]     = {16'b0, v.msg_cap};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= tcsa_pkg::CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      tracker.write_reg(tcsa_pkg::cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // wait for every outcome, then for a cell that gives none to finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // cell generators
  // --------------------------------------------------------------------------
  function automatic cell_t record_cell(bit first, bit last, bit present,
                                        logic [15:0] e, logic [31:0] len,
                                        logic [31:0] offs);
    cell_t c;
    c.first   = first;
    c.last    = last;
    c.x       = $urandom;
    c.y       = $urandom;
    c.present = present;
    c.edge_tx = e;
    c.len     = len;
    c.offs    = offs;
    return c;
  endfunction

  function automatic longint unsigned chain_admission_chain(logic [15:0] e);
    return chunk_admission_tracker::chain_bytes(e);
  endfunction

  function automatic cell_t random_cell(bit first, bit last);
    cell_t           c;
    int unsigned     pick;
    int unsigned     lim;
    longint unsigned chain;
    longint unsigned pool;
    c = record_cell(first, last, 1'b1, 16'($urandom), $urandom, $urandom);
    pool = tracker.cfg.pool_size;
    pick = $urandom_range(99);
    if (pick < 10) begin
      c.present = 1'b0;
    end else if (pick < 92) begin
      // well-formed record, mostly small edges to keep levels short
      lim = tracker.cfg.max_edge;
      if (lim > 256 && $urandom_range(9) != 0) lim = 256;
      c.edge_tx = 16'($urandom_range(lim, 1));
      chain = chain_admission_chain(c.edge_tx);
      c.len = ($urandom_range(1) && chain <= 64'hFFFF_FFFF) ?
              32'(chain) : 32'(chunk_admission_tracker::level_bytes(c.edge_tx));
      if (pool >= c.len) c.offs = $urandom_range(32'(pool - c.len), 0);
      // broken variants of a good record
      if (pick >= 80) begin
        case ($urandom_range(3))
          0: c.len = c.len + 32'($urandom_range(8, 1));
          1: c.offs = 32'(pool - c.len + 1 + $urandom_range(64));
          2: c.edge_tx = '0;
          default: if (tracker.cfg.max_edge != 16'hFFFF)
                     c.edge_tx = tracker.cfg.max_edge + 16'd1;
        endcase
      end
    end
    return c;
  endfunction

  function automatic admit_cfg_t random_regs();
    admit_cfg_t v;
    v.active      = 1'b1;
    v.max_edge    = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(1024, 1));
    v.max_payload = ($urandom_range(2) == 0) ? 32'($urandom_range(40000, 1)) : $urandom;
    v.budget      = $urandom_range(30000, 0);
    v.pool_size   = $urandom_range(2000000, 0);
    v.byte_cap    = $urandom_range(60000, 0);
    v.msg_cap     = 16'($urandom_range(40, 1));
    return v;
  endfunction

  // random batches of 1 to 16 cells; now and then a batch has no first mark
  task automatic run_batches(int n_cells, int hold_at);
    int    left;
    bit    first;
    bit    last;
    left = 0;
    for (int i = 0; i < n_cells; i++) begin
      if (i == hold_at) begin
        // sender holds off until every outcome is back
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (tracker.pending_outcomes.size() != 0) @(negedge clk);
      end
      if (left == 0) begin
        left  = $urandom_range(16, 1);
        first = ($urandom_range(9) != 0);
      end else begin
        first = 1'b0;
      end
      last = (left == 1) && ($urandom_range(9) != 0);
      send_cell(random_cell(first, last));
      left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    admit_cfg_t  v;
    cell_t       c;
    logic [31:0] pool;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pool inactive out of reset
    send_cell(record_cell(1'b1, 1'b0, 1'b1, 16'd4, 32'd8, 32'd0));
    send_cell(record_cell(1'b0, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0));
    settle();

    // directed: each rejection reason, both deferrals, the budget bypass
    v = '{active: 1'b1, max_edge: 16'd100, max_payload: 32'd6000, budget: 32'd100,
          pool_size: 32'd200000, byte_cap: 32'd3000, msg_cap: 16'd40};
    program_regs(v);
    pool = v.pool_size;
    c = record_cell(1'b1, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    c.x = 32'h8000_0000;
    c.y = 32'h7FFF_FFFF;
    send_cell(c);                                                 // not found
    c = record_cell(1'b0, 1'b0, 1'b1, 16'd0, 32'd8, 32'd0);
    c.x = 32'h7FFF_FFFF;
    c.y = 32'h8000_0000;
    send_cell(c);                                                 // zero edge
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd101, 32'd5408, 32'd0));  // edge over limit
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd4, 32'd0, 32'd0));      // zero length
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd100,
                          32'(chain_admission_chain(16'd100)), 32'd0)); // payload over limit
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd8, 32'd33, 32'd0));     // length mismatch
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd64, 32'd2048, 32'd0));  // first payload bypass
    send_cell(record_cell(1'b0, 1'b1, 1'b1, 16'd1, 32'd8, 32'd16));     // budget deferral
    send_cell(record_cell(1'b1, 1'b0, 1'b1, 16'd80, 32'd3200, 32'd0));  // byte buffer full
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd16,
                          32'(chain_admission_chain(16'd16)), 32'd1000)); // full chain found
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd4, 32'd8, pool - 32'd7)); // slice past pool end
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd4, 32'd8, 32'hFFFF_FFFF)); // slice wraps
    send_cell(record_cell(1'b0, 1'b1, 1'b1, 16'd2, 32'd8, pool - 32'd8));
    settle();

    // directed: message list runs out, rest of the batch stays silent
    v.budget  = 32'hFFFF_FFFF;
    v.msg_cap = 16'd2;
    program_regs(v);
    send_cell(record_cell(1'b1, 1'b0, 1'b1, 16'd4, 32'd8, 32'd0));
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd8, 32'd32, 32'd64));
    send_cell(record_cell(1'b0, 1'b0, 1'b1, 16'd16, 32'd128, 32'd0));   // exhausts, not committed
    send_cell(record_cell(1'b0, 1'b1, 1'b1, 16'd4, 32'd8, 32'd0));      // silent
    send_cell(record_cell(1'b1, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0));      // new batch speaks
    settle();

    // widest setting, with a long stretch of no gaps and no stalls
    in_idle_pct   = 0;
    out_stall_pct = 0;
    v = '{active: 1'b1, max_edge: 16'hFFFF, max_payload: 32'hFFFF_FFFF,
          budget: 32'hFFFF_FFFF, pool_size: 32'hFFFF_FFFF, byte_cap: 32'hFFFF_FFFF,
          msg_cap: 16'hFFFF};
    program_regs(v);
    run_batches(100, -1);
    settle();
    in_idle_pct   = 15;
    out_stall_pct = 15;

    // random settings; one phase holds the sender until all is back
    for (int p = 0; p < 4; p++) begin
      program_regs(random_regs());
      run_batches(100, (p == 1) ? 50 : -1);
      settle();
    end

    // pool unloaded
    v = random_regs();
    v.active = 1'b0;
    program_regs(v);
    run_batches(20, -1);
    settle();

    // tightest setting: no message fits
    v = '{active: 1'b1, max_edge: 16'd1, max_payload: 32'd1, budget: 32'd0,
          pool_size: 32'd0, byte_cap: 32'd0, msg_cap: 16'd0};
    program_regs(v);
    run_batches(20, -1);
    settle();

    // back to a loose random setting with small edges
    program_regs(random_regs());
    run_batches(60, -1);
    settle();

    if (tracker.mismatch_count == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
